>>> rtl/hcbd_pkg.sv
// Types, target codes and bank map table shared by the bank decoder files.
package hcbd_pkg;

   // Target codes
   localparam logic [3:0] TGT_RAM    = 4'd0;
   localparam logic [3:0] TGT_BASIC  = 4'd1;
   localparam logic [3:0] TGT_CHAR   = 4'd2;
   localparam logic [3:0] TGT_KERNAL = 4'd3;
   localparam logic [3:0] TGT_CRTLO  = 4'd4;
   localparam logic [3:0] TGT_CRTHI  = 4'd5;
   localparam logic [3:0] TGT_VIDEO  = 4'd6;
   localparam logic [3:0] TGT_SOUND  = 4'd7;
   localparam logic [3:0] TGT_COLOUR = 4'd8;
   localparam logic [3:0] TGT_TIMER1 = 4'd9;
   localparam logic [3:0] TGT_TIMER2 = 4'd10;
   localparam logic [3:0] TGT_IO1    = 4'd11;
   localparam logic [3:0] TGT_IO2    = 4'd12;
   localparam logic [3:0] TGT_PDIR   = 4'd13;
   localparam logic [3:0] TGT_PDATA  = 4'd14;
   localparam logic [3:0] TGT_NONE   = 4'd15;

   // Map entry that marks the I/O bank (shares the video code)
   localparam logic [3:0] MAP_IO = 4'd6;

   localparam int unsigned NUM_ROWS    = 32;
   localparam int unsigned NUM_REGIONS = 6;

   localparam logic [15:0] COLOUR_BASE = 16'hD800;
   localparam logic [15:0] VIDEO_MASK  = 16'h003F;
   localparam logic [15:0] TIMER_MASK  = 16'h000F;

   typedef logic [3:0] target_type;

   typedef struct packed {
      logic        action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [2:0]  port_bits;
      logic        game_line;
      logic        exrom_line;
   } req_payload_type;

   typedef struct packed {
      target_type  target;
      logic [15:0] local_offset;
      logic [7:0]  data_out;
      logic        ultimax;
      logic        open_bus;
   } rsp_payload_type;

   // Regions: 1000-7FFF, 8000-9FFF, A000-BFFF, C000-CFFF, D000-DFFF, E000-FFFF
   localparam target_type BANK_ROWS [NUM_ROWS][NUM_REGIONS] = '{
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd5, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd4, 4'd5, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0},
      '{4'd0, 4'd0, 4'd5, 4'd0, 4'd6, 4'd3},
      '{4'd0, 4'd4, 4'd5, 4'd0, 4'd6, 4'd3},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd4, 4'd1, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd3},
      '{4'd0, 4'd4, 4'd1, 4'd0, 4'd6, 4'd3},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd15, 4'd4, 4'd15, 4'd15, 4'd6, 4'd5},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd3},
      '{4'd0, 4'd0, 4'd1, 4'd0, 4'd6, 4'd3}
   };

   // Map a 4 KB bank number onto its region column
   function automatic logic [2:0] bank_region(input logic [3:0] bank);
      logic [2:0] region;
      case (bank)
         4'h8, 4'h9: region = 3'd1;
         4'hA, 4'hB: region = 3'd2;
         4'hC:       region = 3'd3;
         4'hD:       region = 3'd4;
         4'hE, 4'hF: region = 3'd5;
         default:    region = 3'd0;
      endcase
      return region;
   endfunction

endpackage

>>> rtl/hcbd_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface hcbd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/hcbd_decode.sv
// Combinational decode of one bus access into target, offset and bus flags.
module hcbd_decode (
   input  hcbd_pkg::req_payload_type req_data,
   output hcbd_pkg::rsp_payload_type rsp_data
);

   logic [4:0]              row;
   logic [3:0]              bank;
   logic [3:0]              sub;
   logic [2:0]              region;
   hcbd_pkg::target_type    kind;
   hcbd_pkg::target_type    tgt;
   logic [15:0]             off;
   logic                    obus;
   logic                    wr;

   assign wr     = req_data.action;
   assign row    = {req_data.exrom_line, req_data.game_line, req_data.port_bits};
   assign bank   = req_data.address[15:12];
   assign sub    = req_data.address[11:8];
   assign region = hcbd_pkg::bank_region(bank);
   assign kind   = hcbd_pkg::BANK_ROWS[row][region];

   always_comb begin
      tgt  = kind;
      off  = req_data.address;
      obus = 1'b0;
      if (bank == 4'h0) begin
         if (req_data.address == 16'h0000) begin
            tgt = hcbd_pkg::TGT_PDIR;
         end else if (req_data.address == 16'h0001) begin
            tgt = hcbd_pkg::TGT_PDATA;
         end else begin
            tgt = hcbd_pkg::TGT_RAM;
         end
      end else if (kind == hcbd_pkg::MAP_IO) begin
         // split the I/O bank on address bits 11..8
         case (sub)
            4'h0, 4'h1, 4'h2, 4'h3: begin
               tgt = hcbd_pkg::TGT_VIDEO;
               off = req_data.address & hcbd_pkg::VIDEO_MASK;
            end
            4'h4, 4'h5, 4'h6, 4'h7: tgt = hcbd_pkg::TGT_SOUND;
            4'h8, 4'h9, 4'hA, 4'hB: begin
               tgt = hcbd_pkg::TGT_COLOUR;
               off = req_data.address - hcbd_pkg::COLOUR_BASE;
            end
            4'hC: begin
               tgt = hcbd_pkg::TGT_TIMER1;
               off = req_data.address & hcbd_pkg::TIMER_MASK;
            end
            4'hD: begin
               tgt = hcbd_pkg::TGT_TIMER2;
               off = req_data.address & hcbd_pkg::TIMER_MASK;
            end
            4'hE:    tgt = hcbd_pkg::TGT_IO1;
            default: tgt = hcbd_pkg::TGT_IO2;
         endcase
      end else if (kind == hcbd_pkg::TGT_NONE) begin
         // unmapped: drop writes, float the bus on reads
         off  = 16'h0000;
         obus = ~wr;
      end else if (wr && (kind == hcbd_pkg::TGT_BASIC || kind == hcbd_pkg::TGT_CHAR ||
                          kind == hcbd_pkg::TGT_KERNAL)) begin
         tgt = hcbd_pkg::TGT_RAM;
      end
   end

   assign rsp_data.target       = tgt;
   assign rsp_data.local_offset = off;
   assign rsp_data.data_out     = (wr && tgt != hcbd_pkg::TGT_NONE) ?
                                  req_data.write_data : 8'h00;
   assign rsp_data.ultimax      = req_data.exrom_line & ~req_data.game_line;
   assign rsp_data.open_bus     = obus;

endmodule

>>> rtl/home_computer_bank_decoder.sv
// Top level of the memory bank decoder: input register, decode, result register.
//
// Use: each CPU bus access enters as one transfer on req_ch (action, address,
// write data, processor port bits, game and exrom lines). The block answers
// each access with exactly one transfer on rsp_ch: the target resource, the
// address presented to it, the forwarded write byte, the ultimax flag and
// the open-bus flag for unmapped reads.
// Path: the access is registered at the input, decoded in one pass of table
// lookup and address compares, and captured in the result register, which
// presents it on rsp_ch.
// Throughput: one access per clock, sustained, as long as rsp_ch takes a
// result each cycle.
// Stall: while a result waits in the result register, the input register
// still takes one more access; req_ch.ready drops only when both registers
// are full and rsp_ch.ready is low. Nothing is lost or repeated.
// Reset: synchronous and active high; it empties both registers, so no
// result is presented until a new access arrives. There is no other state.
module home_computer_bank_decoder (
   input  logic        clock,
   input  logic        reset,
   hcbd_chan_if.sink   req_ch,
   hcbd_chan_if.source rsp_ch
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   hcbd_pkg::req_payload_type  in_data_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   hcbd_pkg::rsp_payload_type  out_data_ff;
   hcbd_pkg::rsp_payload_type  dec_data;
   logic                       out_advance;
   logic                       in_take;

   // result register frees up when empty or when its transfer completes
   assign out_advance = ~out_valid_ff | rsp_ch.ready;
   assign req_ch.ready = ~in_valid_ff | out_advance;
   assign in_take = req_ch.valid & req_ch.ready;

   assign in_valid_in  = in_take | (in_valid_ff & ~out_advance);
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   hcbd_decode u_decode (
      .req_data (in_data_ff),
      .rsp_data (dec_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_ch.payload;
      end
      if (out_advance && in_valid_ff) begin
         out_data_ff <= dec_data;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

`ifndef SYNTHESIS
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      in_take |=> in_valid_ff)
      else $error("accepted access not held in input register");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_advance) |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled access lost from input register");

   a_open_bus: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.open_bus) |->
         (out_data_ff.target == hcbd_pkg::TGT_NONE &&
          out_data_ff.local_offset == 16'h0000 && out_data_ff.data_out == 8'h00))
      else $error("open bus result with a mapped target");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.target == hcbd_pkg::TGT_NONE) |->
         (out_data_ff.local_offset == 16'h0000 && out_data_ff.data_out == 8'h00))
      else $error("unmapped access carries offset or data");

   a_io_offset: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_data_ff.target == hcbd_pkg::TGT_TIMER1 ||
                        out_data_ff.target == hcbd_pkg::TGT_TIMER2)) |->
         out_data_ff.local_offset[15:4] == 12'h000)
      else $error("timer offset not masked");
`endif

endmodule
